>>> src/tmcw_pkg.sv
// Shared types, constants and helper functions for the text mode console writer.
// No dependencies; every other file imports this package.
package tmcw_pkg;

    localparam int SCREEN_COLUMNS = 80;
    localparam int SCREEN_ROWS    = 25;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int POS_W  = 7;
    localparam int ADDR_W = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_CLEAR   = 2'd1;
    localparam logic [1:0] REQ_SET_COL = 2'd2;
    localparam logic [1:0] REQ_SET_ROW = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_FOREGROUND = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACKGROUND = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_MAP  = 2'd2;

    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_LINE_FEED = 8'h0A;
    localparam logic [7:0] CH_RETURN    = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    localparam logic [CFG_DATA_W-1:0] COLOR_MAP_RESET = 24'hFAC688;

    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(SCREEN_COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(SCREEN_ROWS - 1);
    localparam logic [POS_W-1:0] COL_LIMIT = POS_W'(SCREEN_COLUMNS);
    localparam logic [POS_W-1:0] ROW_LIMIT = POS_W'(SCREEN_ROWS);

    typedef struct packed {
        logic [1:0]       req_type;
        logic [7:0]       char_code;
        logic [POS_W-1:0] position_value;
    } req_t;

    typedef struct packed {
        logic              status;
        logic              cell_write;
        logic              fill_screen;
        logic [ADDR_W-1:0] cell_address;
        logic [15:0]       cell_value;
        logic [COL_W-1:0]  cursor_column;
        logic [ROW_W-1:0]  cursor_row;
        logic [ADDR_W-1:0] cursor_position;
    } result_t;

    // Linear cell index row * SCREEN_COLUMNS + column, kept to the address width.
    function automatic logic [ADDR_W-1:0] linear_index(input logic [ROW_W-1:0] row,
                                                      input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] prod;
        prod = ADDR_W'(ADDR_W'(row) * ADDR_W'(SCREEN_COLUMNS));
        return prod + ADDR_W'(col);
    endfunction

endpackage

>>> src/tmcw_attr.sv
// Colour configuration registers and the attribute byte built from them.
// Depends on tmcw_pkg.
module tmcw_attr
    import tmcw_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [7:0]             attribute
);

    logic [3:0]            foreground_reg;
    logic [3:0]            background_reg;
    logic [CFG_DATA_W-1:0] color_map_reg;
    logic [2:0]            map_entry [8];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            foreground_reg <= '0;
            background_reg <= '0;
            color_map_reg  <= COLOR_MAP_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FOREGROUND: foreground_reg <= cfg_data[3:0];
                CFG_BACKGROUND: background_reg <= cfg_data[3:0];
                CFG_COLOR_MAP:  color_map_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            map_entry[i] = color_map_reg[3*i +: 3];
        end
    end

    // The top bit of a console colour selects the bright variant of the mapped colour.
    assign attribute = {background_reg[3], map_entry[background_reg[2:0]],
                        foreground_reg[3], map_entry[foreground_reg[2:0]]};

endmodule

>>> src/tmcw_cursor.sv
// Cursor registers and the per-request decode that forms one result word.
// Depends on tmcw_pkg.
module tmcw_cursor
    import tmcw_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  req_t       req,
    input  logic [7:0] attribute,
    output result_t    result
);

    logic [COL_W-1:0] column_reg, column_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [ROW_W-1:0] row_down;
    logic [COL_W-1:0] column_inc;

    assign row_down   = (row_reg == ROW_LAST) ? ROW_LAST : row_reg + ROW_W'(1);
    assign column_inc = column_reg + COL_W'(1);

    always_comb begin
        column_next = column_reg;
        row_next    = row_reg;
        result      = '0;
        case (req.req_type)
            REQ_WRITE: begin
                if (req.char_code == CH_BACKSPACE) begin
                    if (column_reg != '0) begin
                        column_next = column_reg - COL_W'(1);
                    end else if (row_reg != '0) begin
                        row_next    = row_reg - ROW_W'(1);
                        column_next = COL_LAST;
                    end
                end else if (req.char_code == CH_RETURN) begin
                    column_next = '0;
                end else if (req.char_code == CH_LINE_FEED) begin
                    column_next = '0;
                    row_next    = row_down;
                end else begin
                    result.cell_write   = 1'b1;
                    result.cell_address = linear_index(row_reg, column_reg);
                    result.cell_value   = {attribute, req.char_code};
                    if (column_reg == COL_LAST) begin
                        column_next = '0;
                        row_next    = row_down;
                    end else begin
                        column_next = column_inc;
                    end
                end
            end
            REQ_CLEAR: begin
                result.fill_screen = 1'b1;
                result.cell_value  = {attribute, CH_SPACE};
                column_next        = '0;
                row_next           = '0;
            end
            REQ_SET_COL: begin
                if (req.position_value >= COL_LIMIT) begin
                    result.status = 1'b1;
                end else begin
                    column_next = req.position_value[COL_W-1:0];
                end
            end
            REQ_SET_ROW: begin
                if (req.position_value >= ROW_LIMIT) begin
                    result.status = 1'b1;
                end else begin
                    row_next = req.position_value[ROW_W-1:0];
                end
            end
            default: ;
        endcase
        result.cursor_column   = column_next;
        result.cursor_row      = row_next;
        result.cursor_position = linear_index(row_next, column_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            row_reg    <= '0;
        end else if (step) begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

    a_column_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        column_reg <= COL_LAST)
        else $error("cursor column left the screen");

    a_row_on_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= ROW_LAST)
        else $error("cursor row left the screen");

    a_clear_homes: assert property (@(posedge aclk) disable iff (!aresetn)
        step && req.req_type == REQ_CLEAR |=> column_reg == '0 && row_reg == '0)
        else $error("clear did not home the cursor");

    a_reject_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        step && result.status |=> $stable(column_reg) && $stable(row_reg))
        else $error("rejected set request moved the cursor");

endmodule

>>> src/text_mode_console_writer_top.sv
// Top level of the text mode console writer: input register, result register
// and handshakes around tmcw_attr and tmcw_cursor. Depends on tmcw_pkg.
//
//   channel | direction | handshake            | payload
//   s_      | in        | s_valid / s_ready    | s_req_type, s_char_code, s_position_value
//   m_      | out       | m_valid / m_ready    | m_status ... m_cursor_position
//   cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each word passes the input register, then the cursor decode into the result register.
// One word is accepted every cycle while the result side keeps taking words.
// Reset is synchronous and active low; it empties both registers, homes the cursor
// and restores the default colours. A stall on m_ready fills the input register and
// then holds s_ready low. Configuration writes are always accepted.
module text_mode_console_writer_top
    import tmcw_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [1:0]             s_req_type,
    input  logic [7:0]             s_char_code,
    input  logic [POS_W-1:0]       s_position_value,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_status,
    output logic                   m_cell_write,
    output logic                   m_fill_screen,
    output logic [ADDR_W-1:0]      m_cell_address,
    output logic [15:0]            m_cell_value,
    output logic [COL_W-1:0]       m_cursor_column,
    output logic [ROW_W-1:0]       m_cursor_row,
    output logic [ADDR_W-1:0]      m_cursor_position,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic    in_valid_reg;
    req_t    in_req_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    result_t result_next;
    logic    advance;
    logic    fire;
    logic [7:0] attribute;

    assign advance   = !out_valid_reg || m_ready;
    assign fire      = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    tmcw_attr u_attr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .attribute (attribute)
    );

    tmcw_cursor u_cursor (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (fire),
        .req       (in_req_reg),
        .attribute (attribute),
        .result    (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg <= '{req_type: s_req_type, char_code: s_char_code,
                            position_value: s_position_value};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_result_reg <= result_next;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_status          = out_result_reg.status;
    assign m_cell_write      = out_result_reg.cell_write;
    assign m_fill_screen     = out_result_reg.fill_screen;
    assign m_cell_address    = out_result_reg.cell_address;
    assign m_cell_value      = out_result_reg.cell_value;
    assign m_cursor_column   = out_result_reg.cursor_column;
    assign m_cursor_row      = out_result_reg.cursor_row;
    assign m_cursor_position = out_result_reg.cursor_position;

    a_single_command: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_result_reg.cell_write && out_result_reg.fill_screen))
        else $error("cell write and fill issued together");

    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_result_reg))
        else $error("stalled result word changed");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_req_reg))
        else $error("held request word was lost");

endmodule

>>> sim/tmcw_result_check.sv
// Watches the request, result and register channels of the text mode console writer,
// predicts every result word from its own copy of the cursor and colours and compares.
// Depends on tmcw_pkg for the request codes, register indexes and result type.
module tmcw_result_check
    import tmcw_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  logic [1:0]             s_req_type,
    input  logic [7:0]             s_char_code,
    input  logic [POS_W-1:0]       s_position_value,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  logic                   m_status,
    input  logic                   m_cell_write,
    input  logic                   m_fill_screen,
    input  logic [ADDR_W-1:0]      m_cell_address,
    input  logic [15:0]            m_cell_value,
    input  logic [COL_W-1:0]       m_cursor_column,
    input  logic [ROW_W-1:0]       m_cursor_row,
    input  logic [ADDR_W-1:0]      m_cursor_position,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     pending
);

    logic [COL_W-1:0]      cur_col;
    logic [ROW_W-1:0]      cur_row;
    logic [3:0]            fg_colour;
    logic [3:0]            bg_colour;
    logic [CFG_DATA_W-1:0] colour_map;
    result_t               expected_results[$];
    bit                    word_bad;

    function automatic logic [3:0] mapped_colour(input logic [3:0] c);
        logic [2:0] entry;
        entry = colour_map[3*c[2:0] +: 3];
        return {c[3], entry};
    endfunction

    function automatic logic [ADDR_W-1:0] cell_index(input logic [ROW_W-1:0] row,
                                                     input logic [COL_W-1:0] col);
        int unsigned lin;
        lin = row * SCREEN_COLUMNS + col;
        return lin[ADDR_W-1:0];
    endfunction

    task automatic predict_console_result(input logic [1:0] req, input logic [7:0] ch,
                                          input logic [POS_W-1:0] pos);
        result_t r;
        r = '0;
        case (req)
            REQ_WRITE: begin
                if (ch == CH_BACKSPACE) begin
                    if (cur_col != 0) begin
                        cur_col = cur_col - 1'b1;
                    end else if (cur_row != 0) begin
                        cur_row = cur_row - 1'b1;
                        cur_col = COL_LAST;
                    end
                end else if (ch == CH_RETURN) begin
                    cur_col = '0;
                end else if (ch == CH_LINE_FEED) begin
                    cur_col = '0;
                    if (cur_row < ROW_LAST) cur_row = cur_row + 1'b1;
                end else begin
                    r.cell_write   = 1'b1;
                    r.cell_address = cell_index(cur_row, cur_col);
                    r.cell_value   = {mapped_colour(bg_colour), mapped_colour(fg_colour), ch};
                    if (cur_col == COL_LAST) begin
                        cur_col = '0;
                        if (cur_row < ROW_LAST) cur_row = cur_row + 1'b1;
                    end else begin
                        cur_col = cur_col + 1'b1;
                    end
                end
            end
            REQ_CLEAR: begin
                r.fill_screen = 1'b1;
                r.cell_value  = {mapped_colour(bg_colour), mapped_colour(fg_colour), CH_SPACE};
                cur_col = '0;
                cur_row = '0;
            end
            REQ_SET_COL: begin
                if (pos >= COL_LIMIT) r.status = 1'b1;
                else cur_col = pos;
            end
            default: begin
                if (pos >= ROW_LIMIT) r.status = 1'b1;
                else cur_row = pos[ROW_W-1:0];
            end
        endcase
        r.cursor_column   = cur_col;
        r.cursor_row      = cur_row;
        r.cursor_position = cell_index(cur_row, cur_col);
        expected_results.push_back(r);
    endtask

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] actual);
        if (actual !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, actual);
            word_bad = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            cur_col    = '0;
            cur_row    = '0;
            fg_colour  = '0;
            bg_colour  = '0;
            colour_map = COLOR_MAP_RESET;
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FOREGROUND: fg_colour  = cfg_data[3:0];
                    CFG_BACKGROUND: bg_colour  = cfg_data[3:0];
                    CFG_COLOR_MAP:  colour_map = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result word with no request outstanding", $time);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    word_bad = 1'b0;
                    compare_field("status", want.status, m_status);
                    compare_field("cell_write", want.cell_write, m_cell_write);
                    compare_field("fill_screen", want.fill_screen, m_fill_screen);
                    compare_field("cell_address", want.cell_address, m_cell_address);
                    compare_field("cell_value", want.cell_value, m_cell_value);
                    compare_field("cursor_column", want.cursor_column, m_cursor_column);
                    compare_field("cursor_row", want.cursor_row, m_cursor_row);
                    compare_field("cursor_position", want.cursor_position,
                                  m_cursor_position);
                    if (word_bad) fail_count++;
                end
            end
            if (s_valid && s_ready) begin
                predict_console_result(s_req_type, s_char_code, s_position_value);
            end
        end
        pending = expected_results.size();
    end

endmodule

>>> sim/text_mode_console_writer_top_test.sv
// Testbench top for the text mode console writer: clock, reset, request and register
// stimulus, random back-pressure and the verdict. Depends on tmcw_pkg, the block and
// tmcw_result_check, which does all prediction and comparison.
module text_mode_console_writer_top_test;
    import tmcw_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASE_WORDS    = 250;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [1:0]             s_req_type = REQ_WRITE;
    logic [7:0]             s_char_code = '0;
    logic [POS_W-1:0]       s_position_value = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic                   m_status;
    logic                   m_cell_write;
    logic                   m_fill_screen;
    logic [ADDR_W-1:0]      m_cell_address;
    logic [15:0]            m_cell_value;
    logic [COL_W-1:0]       m_cursor_column;
    logic [ROW_W-1:0]       m_cursor_row;
    logic [ADDR_W-1:0]      m_cursor_position;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_FOREGROUND;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   steady = 1'b0;
    int                     fail_count;
    int                     pending;
    int                     idle_cycles = 0;

    always #5 aclk = ~aclk;

    text_mode_console_writer_top i_dut (.*);

    tmcw_result_check i_check (.*);

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= 19);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] req, input logic [7:0] ch,
                                input logic [POS_W-1:0] pos);
        while (!steady && $urandom_range(0, 99) < 19) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid          <= 1'b1;
        s_req_type       <= req;
        s_char_code      <= ch;
        s_position_value <= pos;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_for_results();
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_request();
        int               pick;
        logic [1:0]       req;
        logic [7:0]       ch;
        logic [POS_W-1:0] pos;
        pick = $urandom_range(0, 99);
        ch   = 8'($urandom_range(0, 255));
        pos  = POS_W'($urandom_range(0, 127));
        if (pick < 4) begin
            req = REQ_CLEAR;
        end else if (pick < 62) begin
            req  = REQ_WRITE;
            pick = $urandom_range(0, 99);
            if (pick < 8) ch = CH_LINE_FEED;
            else if (pick < 14) ch = CH_BACKSPACE;
            else if (pick < 17) ch = CH_RETURN;
        end else if (pick < 81) begin
            req = REQ_SET_COL;
            if ($urandom_range(0, 1)) pos = POS_W'($urandom_range(74, 84));
        end else begin
            req = REQ_SET_ROW;
            if ($urandom_range(0, 1)) pos = POS_W'($urandom_range(20, 27));
        end
        send_request(req, ch, pos);
    endtask

    initial begin
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        send_request(REQ_CLEAR, 8'hFF, 7'h7F);
        send_request(REQ_WRITE, 8'h41, 7'h00);
        send_request(REQ_WRITE, 8'h00, 7'h7F);
        send_request(REQ_WRITE, 8'hFF, 7'h2A);
        send_request(REQ_WRITE, 8'h80, 7'h55);
        send_request(REQ_WRITE, CH_BACKSPACE, 7'h00);
        send_request(REQ_WRITE, CH_RETURN, 7'h00);
        send_request(REQ_WRITE, CH_LINE_FEED, 7'h00);
        send_request(REQ_CLEAR, 8'h00, 7'h00);
        send_request(REQ_WRITE, CH_BACKSPACE, 7'h00);
        send_request(REQ_SET_ROW, 8'h00, 7'd3);
        send_request(REQ_SET_COL, 8'h00, 7'd0);
        send_request(REQ_WRITE, CH_BACKSPACE, 7'h00);
        send_request(REQ_SET_COL, 8'h00, COL_LIMIT);
        send_request(REQ_SET_COL, 8'hFF, 7'h7F);
        send_request(REQ_SET_COL, 8'h00, COL_LAST);
        send_request(REQ_SET_ROW, 8'h00, ROW_LIMIT);
        send_request(REQ_SET_ROW, 8'hFF, 7'h7F);
        send_request(REQ_SET_ROW, 8'h00, POS_W'(ROW_LAST));
        send_request(REQ_WRITE, CH_LINE_FEED, 7'h00);
        send_request(REQ_SET_COL, 8'h00, COL_LAST);
        send_request(REQ_WRITE, 8'h5A, 7'h00);
        send_request(REQ_WRITE, 8'h7E, 7'h00);

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_register(CFG_FOREGROUND, CFG_DATA_W'(15));
                    write_register(CFG_BACKGROUND, CFG_DATA_W'(0));
                    write_register(CFG_COLOR_MAP, 24'hFFFFFF);
                end
                1: begin
                    write_register(CFG_FOREGROUND, CFG_DATA_W'(0));
                    write_register(CFG_BACKGROUND, CFG_DATA_W'(15));
                    write_register(CFG_COLOR_MAP, 24'h000000);
                end
                2: begin
                    write_register(CFG_FOREGROUND, CFG_DATA_W'(7));
                    write_register(CFG_BACKGROUND, CFG_DATA_W'(8));
                    write_register(CFG_COLOR_MAP, COLOR_MAP_RESET);
                    steady <= 1'b1;
                end
                default: begin
                    steady <= 1'b0;
                    write_register(CFG_FOREGROUND, CFG_DATA_W'($urandom()));
                    write_register(CFG_BACKGROUND, CFG_DATA_W'($urandom()));
                    write_register(CFG_COLOR_MAP, CFG_DATA_W'($urandom()));
                    write_register(CFG_UNUSED, CFG_DATA_W'($urandom()));
                end
            endcase
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (phase == 1 && n == PHASE_WORDS / 2) wait_for_results();
                send_random_request();
            end
        end

        wait_for_results();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
